[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/shabc_pkg.sv]
// ---------------------------------------------------------------------------
// shabc_pkg
// shared types, codes, round constants and sigma functions for sha-256
// ---------------------------------------------------------------------------
package shabc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned RndW   = $clog2(Rounds);
  localparam int unsigned WinLen = 16;
  localparam int unsigned MsgW   = $clog2(WinLen);
  localparam int unsigned SlotW  = 3;

  typedef logic [WordW-1:0] word_t;
  typedef logic [7:0][WordW-1:0] word8_t;

  // request kinds carried in tuser
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_MSG  = 1'b1
  } action_t;

  // control from the sequencer to the datapath parts
  typedef struct packed {
    logic push;  // shift a message word into the window
    logic init;  // copy chaining state into the working variables
    logic step;  // run one round / one schedule step
  } shabc_ctrl_t;

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t round_k(input logic [RndW-1:0] r);
    case (r)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

[rtl/shabc_sched.sv]
// ---------------------------------------------------------------------------
// shabc_sched
// rolling 16-word message schedule window, oldest word at tap zero
// ---------------------------------------------------------------------------
module shabc_sched (
  input  logic                  clk,
  input  shabc_pkg::shabc_ctrl_t ctrl,
  input  shabc_pkg::word_t      msg_word,
  output shabc_pkg::word_t      w_cur
);

  shabc_pkg::word_t win [shabc_pkg::WinLen];
  shabc_pkg::word_t w_new;
  shabc_pkg::word_t shift_in;

  // w[t+16] from the window holding w[t..t+15]
  assign w_new = shabc_pkg::small_sigma1(win[14]) + win[9]
               + shabc_pkg::small_sigma0(win[1]) + win[0];
  assign shift_in = ctrl.push ? msg_word : w_new;
  assign w_cur = win[0];

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      for (int i = 0; i < shabc_pkg::WinLen - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[shabc_pkg::WinLen-1] <= shift_in;
    end
  end

endmodule

[rtl/shabc_round.sv]
// ---------------------------------------------------------------------------
// shabc_round
// working variables a..h and the single shared round unit
// ---------------------------------------------------------------------------
module shabc_round (
  input  logic                          clk,
  input  logic                          rst,
  input  shabc_pkg::shabc_ctrl_t        ctrl,
  input  logic [shabc_pkg::RndW-1:0]    rnd,
  input  shabc_pkg::word_t              w_cur,
  input  shabc_pkg::word8_t             chain,
  output shabc_pkg::word8_t             vars
);

  shabc_pkg::word_t t1;
  shabc_pkg::word_t t2;
  shabc_pkg::word_t ch;
  shabc_pkg::word_t maj;

  // index 0 is a, index 7 is h
  assign ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1  = vars[7] + shabc_pkg::big_sigma1(vars[4]) + ch
             + shabc_pkg::round_k(rnd) + w_cur;
  assign t2  = shabc_pkg::big_sigma0(vars[0]) + maj;

  always_ff @(posedge clk) begin
    if (rst) begin
      vars <= '0;
    end else if (ctrl.init) begin
      vars <= chain;
    end else if (ctrl.step) begin
      // h..f and d..b move down, e and a take the new values
      vars[7:5] <= vars[6:4];
      vars[4]   <= vars[3] + t1;
      vars[3:1] <= vars[2:0];
      vars[0]   <= t1 + t2;
    end
  end

endmodule

[rtl/sha256_block_compress_top.sv]
// ---------------------------------------------------------------------------
// sha256_block_compress_top
// sha-256 compression of one 64-byte block fed one 32-bit word per request
//
// each input request either loads one of the eight chaining words (tuser 0,
// slot and word in tdata) or appends one big-endian message word (tuser 1).
// loads and message words are taken only while the block is idle. the
// sixteenth message word starts a compression: the input drops tready, one
// round unit runs the 64 rounds, one round per cycle, while the schedule
// window rolls alongside, an add state sums the working variables into the
// chaining state, and the eight updated words then leave in slot order, one
// per output request, the last with tlast. a block therefore keeps the input
// off until the last of its digest words has been accepted downstream. the
// chaining state stays in place, so following blocks chain without a reload;
// padding and the initial vector are up to the user. reset clears the
// chaining words and working variables to zero
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_block_compress_top (
  input  logic        clk,
  input  logic        rst,
  // input request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [2:0] hash_slot, [34:3] data_word, rest zero
  input  logic        s_axis_tuser,   // [0] action
  // digest channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] digest_slot, rest zero
  output logic        m_axis_tlast    // last_of_run
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                           state;
  state_t                           state_next;
  logic [shabc_pkg::MsgW-1:0]       msg_count;
  logic [shabc_pkg::RndW-1:0]       round_count;
  logic [shabc_pkg::SlotW-1:0]      emit_slot;
  shabc_pkg::word8_t                chain;
  shabc_pkg::word8_t                vars;
  shabc_pkg::word_t                 w_cur;
  shabc_pkg::shabc_ctrl_t           ctrl;

  logic                             in_acc;
  logic                             out_acc;
  logic                             is_msg;
  logic [shabc_pkg::SlotW-1:0]      in_slot;
  shabc_pkg::word_t                 in_word;
  logic                             last_round;
  logic                             last_slot;

  // request fields
  assign in_slot = s_axis_tdata[2:0];
  assign in_word = s_axis_tdata[34:3];
  assign is_msg  = (s_axis_tuser == shabc_pkg::ACT_MSG);

  // input only taken between blocks and out of reset
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (state == ST_EMIT);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign last_slot     = (emit_slot == {shabc_pkg::SlotW{1'b1}});
  assign last_round    = (round_count == {shabc_pkg::RndW{1'b1}});

  assign m_axis_tdata  = {5'b0, emit_slot, chain[emit_slot]};
  assign m_axis_tlast  = last_slot;

  // datapath control
  always_comb begin
    ctrl.push = in_acc && is_msg;
    ctrl.init = in_acc && is_msg && (msg_count == {shabc_pkg::MsgW{1'b1}});
    ctrl.step = (state == ST_ROUND);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctrl.init) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (last_round) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc && last_slot) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      msg_count   <= '0;
      round_count <= '0;
      emit_slot   <= '0;
      chain       <= '0;
    end else begin
      state <= state_next;
      // chaining word load, no effect on held message words
      if (in_acc && !is_msg) begin
        chain[in_slot] <= in_word;
      end
      if (ctrl.push) begin
        msg_count <= msg_count + 1'b1;
      end
      // wraps to zero after the last round
      if (ctrl.step) begin
        round_count <= round_count + 1'b1;
      end
      // feed-forward into the chaining state
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (out_acc) begin
        emit_slot <= emit_slot + 1'b1;
      end
    end
  end

  shabc_sched u_sched (
    .clk      (clk),
    .ctrl     (ctrl),
    .msg_word (in_word),
    .w_cur    (w_cur)
  );

  shabc_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .rnd   (round_count),
    .w_cur (w_cur),
    .chain (chain),
    .vars  (vars)
  );

  // sixteenth message word starts the rounds from round zero
  `ASSERT_NEXT(a_start_rounds, clk, rst, ctrl.init, (state == ST_ROUND) && (round_count == '0))
  // the final round hands over to the feed-forward add
  `ASSERT_NEXT(a_round_to_add, clk, rst, (state == ST_ROUND) && last_round, state == ST_ADD)
  // no message words held while the digest is going out
  `ASSERT_SAME(a_emit_empty, clk, rst, m_axis_tvalid, msg_count == '0)
  // digest ends after the flagged word and slot restarts at zero
  `ASSERT_NEXT(a_emit_done, clk, rst, out_acc && last_slot, (state == ST_IDLE) && (emit_slot == '0))

endmodule

[bench/digest_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// digest_checker
// watches both streams of the sha-256 block compressor, predicts every digest
// word from the accepted requests and compares it with what leaves the block
// ---------------------------------------------------------------------------
module digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [2:0] hash_slot, [34:3] data_word, rest zero
  input  logic        s_axis_tuser,   // [0] action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] digest_slot, rest zero
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    shabc_pkg::word_t word;
    logic [2:0]       slot;
    logic             last;
  } digest_t;

  localparam shabc_pkg::word_t K256 [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  shabc_pkg::word_t chain_words [8];
  shabc_pkg::word_t msg_window [16];
  logic [3:0]       msg_count;
  digest_t          expected_digests [$];

  initial fail_count = 0;

  function automatic shabc_pkg::word_t rotr32(input shabc_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64 rounds over the rolling schedule window, then fold into the chain
  function automatic void run_compression();
    shabc_pkg::word_t v [8];
    shabc_pkg::word_t w15, w2, t1, t2;
    int               slot;
    for (int i = 0; i < 8; i++) v[i] = chain_words[i];
    for (int r = 0; r < 64; r++) begin
      slot = r % 16;
      if (r >= 16) begin
        w15 = msg_window[(slot + 1) % 16];
        w2  = msg_window[(slot + 14) % 16];
        msg_window[slot] = msg_window[slot]
          + (rotr32(w15, 7) ^ rotr32(w15, 18) ^ (w15 >> 3))
          + msg_window[(slot + 9) % 16]
          + (rotr32(w2, 17) ^ rotr32(w2, 19) ^ (w2 >> 10));
      end
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K256[r] + msg_window[slot];
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
  endfunction

  task automatic report_mismatch(input string what, input shabc_pkg::word_t got,
                                 input shabc_pkg::word_t want);
    $display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    digest_t want;
    if (rst) begin
      for (int i = 0; i < 8; i++) chain_words[i] = '0;
      msg_count = '0;
      expected_digests.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_digests.size() == 0) begin
          report_mismatch("digest with nothing pending", m_axis_tdata[31:0], '0);
        end else begin
          want = expected_digests.pop_front();
          if (m_axis_tdata[31:0] != want.word)
            report_mismatch("digest_word", m_axis_tdata[31:0], want.word);
          if (m_axis_tdata[34:32] != want.slot)
            report_mismatch("digest_slot", 32'(m_axis_tdata[34:32]), 32'(want.slot));
          if (m_axis_tlast != want.last)
            report_mismatch("last_of_run", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (shabc_pkg::action_t'(s_axis_tuser) == shabc_pkg::ACT_LOAD) begin
          chain_words[s_axis_tdata[2:0]] = s_axis_tdata[34:3];
        end else begin
          msg_window[msg_count] = s_axis_tdata[34:3];
          msg_count = msg_count + 1'b1;
          if (msg_count == 0) begin
            run_compression();
            for (int i = 0; i < 8; i++)
              expected_digests.push_back(digest_t'{chain_words[i], 3'(i), i == 7});
          end
        end
      end
    end
    pending = expected_digests.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives chaining loads and message blocks into the sha-256 compressor with
// random gaps and output stalls; the checker predicts and compares digests
// ---------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [2:0] hash_slot, [34:3] data_word, rest zero
  logic        s_axis_tuser;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] digest_slot, rest zero
  logic        m_axis_tlast;

  int   fail_count;
  int   pending;
  int   sent_count;
  logic tx_idle_on;
  logic rx_idle_on;
  logic rx_hold_request;   // asks the receiver for one long hold-off

  sha256_block_compress_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  digest_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // this timeout is many times longer than the slowest whole run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // digest receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left    = 0;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        // this cycle counts as the first of the stall burst
        stall_left = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // mostly random words, with the all-zero, all-one and one-hot extremes mixed in
  function automatic shabc_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000 >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // one request, preceded now and then by an idle burst carrying junk on tdata
  task automatic send_request(input shabc_pkg::action_t act, input logic [2:0] slot,
                              input shabc_pkg::word_t word);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {5'b0, 32'($urandom()), 3'($urandom_range(0, 7))};
        s_axis_tuser  <= 1'($urandom_range(0, 1));
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, word, slot};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
  endtask

  // sixteen message words with random content, stray chaining loads mixed in
  task automatic send_block();
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_request(shabc_pkg::ACT_LOAD, 3'($urandom_range(0, 7)), rand_word());
      send_request(shabc_pkg::ACT_MSG, 3'($urandom_range(0, 7)), rand_word());
    end
  endtask

  initial begin : stimulus
    rst             = 1'b1;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = shabc_pkg::ACT_LOAD;
    sent_count      = 0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    rx_hold_request = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: chaining extremes in slots 0 to 3 and random words in 4 to 7, then
    // one block opening with extreme message words, a chaining load half way through it
    send_request(shabc_pkg::ACT_LOAD, 3'd0, 32'hffff_ffff);
    send_request(shabc_pkg::ACT_LOAD, 3'd1, 32'h0000_0000);
    send_request(shabc_pkg::ACT_LOAD, 3'd2, 32'h8000_0000);
    send_request(shabc_pkg::ACT_LOAD, 3'd3, 32'h0000_0001);
    for (int s = 4; s < 8; s++) send_request(shabc_pkg::ACT_LOAD, 3'(s), $urandom());
    send_request(shabc_pkg::ACT_MSG, 3'd7, 32'hffff_ffff);
    send_request(shabc_pkg::ACT_MSG, 3'd0, 32'h0000_0000);
    send_request(shabc_pkg::ACT_MSG, 3'd5, 32'h8000_0000);
    send_request(shabc_pkg::ACT_MSG, 3'd2, 32'h0000_0001);
    for (int i = 4; i < 16; i++) begin
      // load during a block must not disturb the words already held
      if (i == 8) send_request(shabc_pkg::ACT_LOAD, 3'd5, 32'hffff_ffff);
      send_request(shabc_pkg::ACT_MSG, 3'($urandom_range(0, 7)), rand_word());
    end

    // random: mostly well-formed blocks that chain on, some loose loads
    while (sent_count < 200) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3))
          send_request(shabc_pkg::ACT_LOAD, 3'($urandom_range(0, 7)), rand_word());
      end else begin
        send_block();
      end
    end

    // receiver holds off while blocks keep coming, so the input backs up
    rx_hold_request = 1'b1;
    repeat (3) send_block();

    // closing stretch with no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (2) send_block();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
